// ===== src/bghg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bghg_pkg;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic [7:0] hue_half_deg;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic [7:0] gray;
	} res_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sec_t;

	// quotient bits of each divider lane, one bit per pipeline stage
	localparam int QuoW = 8;
	localparam int RemW = 16;

	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [7:0]      den;
		logic [QuoW-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic [7:0] brightness;
		sec_t       sector;
		logic       neg;
		logic [7:0] gray;
	} side_t;

	localparam int GraySumW = 18;
	localparam int GrayRecipW = 19;
	localparam int GrayProdW = GraySumW + GrayRecipW;
	localparam logic [GraySumW-1:0] WeightR = 18'd299;
	localparam logic [GraySumW-1:0] WeightG = 18'd587;
	localparam logic [GraySumW-1:0] WeightB = 18'd114;
	localparam logic [GraySumW-1:0] GrayBias = 18'd500;
	// ceil(2^28 / 1000): exact floor division by 1000 for sums below 2^18
	localparam logic [GrayRecipW-1:0] GrayRecip = 19'd268436;
	localparam int GrayShift = 28;

	localparam logic signed [9:0] HueRed = 10'sd0;
	localparam logic signed [9:0] HueGreen = 10'sd120;
	localparam logic signed [9:0] HueBlue = 10'sd240;
	localparam logic signed [9:0] HueWrap = 10'sd360;

endpackage

`default_nettype wire

// ===== src/bghg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bghg_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire bghg_pkg::pix_t      pixel,
	output logic                     out_valid,
	output bghg_pkg::div_lane_t      sat_lane,
	output bghg_pkg::div_lane_t      hue_lane,
	output bghg_pkg::side_t          side
);

	logic           valid_s1;
	bghg_pkg::pix_t pix_s1;

	logic [7:0]        hi;
	logic [7:0]        lo;
	logic [7:0]        span;
	bghg_pkg::sec_t    sector;
	logic signed [8:0] diff;
	logic [8:0]        diff_neg;
	logic [7:0]        mag;
	logic [bghg_pkg::GraySumW-1:0] gray_sum;

	logic                          valid_s2;
	bghg_pkg::div_lane_t           sat_s2;
	bghg_pkg::div_lane_t           hue_s2;
	logic [7:0]                    hi_s2;
	bghg_pkg::sec_t                sector_s2;
	logic                          neg_s2;
	logic [bghg_pkg::GraySumW-1:0] gray_sum_s2;

	logic [bghg_pkg::GrayProdW-1:0] gray_prod;

	logic                valid_s3;
	bghg_pkg::div_lane_t sat_s3;
	bghg_pkg::div_lane_t hue_s3;
	bghg_pkg::side_t     side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel;
	end

	always_comb begin
		hi = pix_s1.red;
		if (pix_s1.green > hi) hi = pix_s1.green;
		if (pix_s1.blue > hi) hi = pix_s1.blue;
		lo = pix_s1.red;
		if (pix_s1.green < lo) lo = pix_s1.green;
		if (pix_s1.blue < lo) lo = pix_s1.blue;
		span = hi - lo;

		// ties go to red first, then green
		if (hi == pix_s1.red) begin
			sector = bghg_pkg::SEC_RED;
			diff = $signed({1'b0, pix_s1.green}) - $signed({1'b0, pix_s1.blue});
		end else if (hi == pix_s1.green) begin
			sector = bghg_pkg::SEC_GREEN;
			diff = $signed({1'b0, pix_s1.blue}) - $signed({1'b0, pix_s1.red});
		end else begin
			sector = bghg_pkg::SEC_BLUE;
			diff = $signed({1'b0, pix_s1.red}) - $signed({1'b0, pix_s1.green});
		end
		diff_neg = 9'(-diff);
		mag = diff[8] ? diff_neg[7:0] : diff[7:0];

		gray_sum = bghg_pkg::GraySumW'(pix_s1.red) * bghg_pkg::WeightR
			+ bghg_pkg::GraySumW'(pix_s1.green) * bghg_pkg::WeightG
			+ bghg_pkg::GraySumW'(pix_s1.blue) * bghg_pkg::WeightB
			+ bghg_pkg::GrayBias;
	end

	// a zero divisor only comes with a zero dividend: divide by one instead
	always_ff @(posedge clk) begin
		sat_s2.rem  <= ({8'd0, span} << 8) - {8'd0, span};
		sat_s2.den  <= (hi == 8'd0) ? 8'd1 : hi;
		sat_s2.quo  <= '0;
		hue_s2.rem  <= ({8'd0, mag} << 6) - ({8'd0, mag} << 2);
		hue_s2.den  <= (span == 8'd0) ? 8'd1 : span;
		hue_s2.quo  <= '0;
		hi_s2       <= hi;
		sector_s2   <= sector;
		neg_s2      <= diff[8];
		gray_sum_s2 <= gray_sum;
	end

	assign gray_prod = bghg_pkg::GrayProdW'(gray_sum_s2)
		* bghg_pkg::GrayProdW'(bghg_pkg::GrayRecip);

	always_ff @(posedge clk) begin
		sat_s3             <= sat_s2;
		hue_s3             <= hue_s2;
		side_s3.brightness <= hi_s2;
		side_s3.sector     <= sector_s2;
		side_s3.neg        <= neg_s2;
		side_s3.gray       <= gray_prod[bghg_pkg::GrayShift +: 8];
	end

	assign out_valid = valid_s3;
	assign sat_lane  = sat_s3;
	assign hue_lane  = hue_s3;
	assign side      = side_s3;

endmodule

`default_nettype wire

// ===== src/bghg_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bghg_divider (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire bghg_pkg::div_lane_t sat_in,
	input  wire bghg_pkg::div_lane_t hue_in,
	input  wire bghg_pkg::side_t     side_in,
	output logic                     out_valid,
	output bghg_pkg::div_lane_t      sat_out,
	output bghg_pkg::div_lane_t      hue_out,
	output bghg_pkg::side_t          side_out
);

	localparam int Steps = bghg_pkg::QuoW;

	logic                valid_s [Steps];
	bghg_pkg::div_lane_t sat_s   [Steps];
	bghg_pkg::div_lane_t hue_s   [Steps];
	bghg_pkg::side_t     side_s  [Steps];

	logic                v_src    [Steps];
	bghg_pkg::div_lane_t sat_src  [Steps];
	bghg_pkg::div_lane_t hue_src  [Steps];
	bghg_pkg::side_t     side_src [Steps];
	bghg_pkg::div_lane_t sat_nx   [Steps];
	bghg_pkg::div_lane_t hue_nx   [Steps];

	// one restoring step: subtract the divisor shifted to this quotient bit
	function automatic bghg_pkg::div_lane_t div_step(
		input bghg_pkg::div_lane_t lane,
		input int                  bit_pos
	);
		bghg_pkg::div_lane_t         res;
		logic [bghg_pkg::RemW-1:0]   d_sh;
		res = lane;
		d_sh = {{(bghg_pkg::RemW-8){1'b0}}, lane.den} << bit_pos;
		if (lane.rem >= d_sh) begin
			res.rem = lane.rem - d_sh;
			res.quo[bit_pos[$clog2(bghg_pkg::QuoW)-1:0]] = 1'b1;
		end
		return res;
	endfunction

	always_comb begin
		v_src[0]    = in_valid;
		sat_src[0]  = sat_in;
		hue_src[0]  = hue_in;
		side_src[0] = side_in;
		for (int i = 1; i < Steps; i++) begin
			v_src[i]    = valid_s[i-1];
			sat_src[i]  = sat_s[i-1];
			hue_src[i]  = hue_s[i-1];
			side_src[i] = side_s[i-1];
		end
		for (int i = 0; i < Steps; i++) begin
			sat_nx[i] = div_step(sat_src[i], Steps - 1 - i);
			hue_nx[i] = div_step(hue_src[i], Steps - 1 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Steps; i++) valid_s[i] <= 1'b0;
		end else begin
			for (int i = 0; i < Steps; i++) valid_s[i] <= v_src[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Steps; i++) begin
			sat_s[i]  <= sat_nx[i];
			hue_s[i]  <= hue_nx[i];
			side_s[i] <= side_src[i];
		end
	end

	assign out_valid = valid_s[Steps-1];
	assign sat_out   = sat_s[Steps-1];
	assign hue_out   = hue_s[Steps-1];
	assign side_out  = side_s[Steps-1];

endmodule

`default_nettype wire

// ===== src/bghg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bghg_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire bghg_pkg::div_lane_t sat_lane,
	input  wire bghg_pkg::div_lane_t hue_lane,
	input  wire bghg_pkg::side_t     side,
	output logic                     done,
	output bghg_pkg::res_t           result
);

	logic signed [9:0] base;
	logic signed [9:0] q_s;
	logic signed [9:0] hue;
	logic [9:0]        hue_u;

	logic           done_q;
	bghg_pkg::res_t res_q;

	always_comb begin
		case (side.sector)
			bghg_pkg::SEC_RED:   base = bghg_pkg::HueRed;
			bghg_pkg::SEC_GREEN: base = bghg_pkg::HueGreen;
			bghg_pkg::SEC_BLUE:  base = bghg_pkg::HueBlue;
			default:             base = bghg_pkg::HueRed;
		endcase
		// quotient magnitude carries the sign of the difference
		q_s = $signed({2'b00, hue_lane.quo});
		hue = side.neg ? (base - q_s) : (base + q_s);
		if (hue < 0) hue = hue + bghg_pkg::HueWrap;
		hue_u = hue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q.hue_half_deg <= hue_u[8:1];
		res_q.saturation   <= sat_lane.quo;
		res_q.brightness   <= side.brightness;
		res_q.gray         <= side.gray;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== src/bgr_to_hsv_and_gray_pixel.sv =====
// Throughput: one pixel per cycle; busy stays low, the pipeline never stops.
// Depth: 3 front stages, 8 divider stages (one quotient bit each), 1 output register.
// Reset: arst_n clears every valid bit; requests in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module bgr_to_hsv_and_gray_pixel (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire bghg_pkg::pix_t pixel,
	output logic                done,
	output bghg_pkg::res_t      result
);

	logic                front_valid;
	bghg_pkg::div_lane_t front_sat;
	bghg_pkg::div_lane_t front_hue;
	bghg_pkg::side_t     front_side;

	logic                div_valid;
	bghg_pkg::div_lane_t div_sat;
	bghg_pkg::div_lane_t div_hue;
	bghg_pkg::side_t     div_side;

	assign busy = 1'b0;

	bghg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.pixel     (pixel),
		.out_valid (front_valid),
		.sat_lane  (front_sat),
		.hue_lane  (front_hue),
		.side      (front_side)
	);

	bghg_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.sat_in    (front_sat),
		.hue_in    (front_hue),
		.side_in   (front_side),
		.out_valid (div_valid),
		.sat_out   (div_sat),
		.hue_out   (div_hue),
		.side_out  (div_side)
	);

	bghg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.sat_lane (div_sat),
		.hue_lane (div_hue),
		.side     (div_side),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== verif/bgr_to_hsv_and_gray_pixel_tb.sv =====
`timescale 1ns / 1ps

module bgr_to_hsv_and_gray_pixel_tb;

	localparam int NumRandom = 1400;
	localparam int QuietTail = 300;
	localparam int DrainLimit = 1000;
	localparam int PipeDepth = 12;

	class hsv_scoreboard;
		bghg_pkg::res_t expected_q[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		// hue in half degrees, saturation, brightness and luma of one pixel
		function bghg_pkg::res_t hsv_gray_of(bghg_pkg::pix_t p);
			int b, g, r, hi, lo, span, h;
			bghg_pkg::res_t q;
			b = int'(p.blue);
			g = int'(p.green);
			r = int'(p.red);
			hi = (b > g) ? b : g;
			hi = (hi > r) ? hi : r;
			lo = (b < g) ? b : g;
			lo = (lo < r) ? lo : r;
			span = hi - lo;
			q.saturation = (hi != 0) ? 8'((255 * span) / hi) : 8'd0;
			h = 0;
			if (span != 0) begin
				// red beats green, green beats blue on a tie for the maximum
				if (hi == r)
					h = (60 * (g - b)) / span;
				else if (hi == g)
					h = 120 + (60 * (b - r)) / span;
				else
					h = 240 + (60 * (r - g)) / span;
				if (h < 0)
					h += 360;
			end
			q.hue_half_deg = 8'(h / 2);
			q.brightness = 8'(hi);
			q.gray = 8'((299 * r + 587 * g + 114 * b + 500) / 1000);
			return q;
		endfunction

		function void note_request(bghg_pkg::pix_t p);
			expected_q.push_back(hsv_gray_of(p));
		endfunction

		function void check_result(bghg_pkg::res_t got);
			bghg_pkg::res_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result h=%0d s=%0d v=%0d y=%0d with no request pending",
					got.hue_half_deg, got.saturation, got.brightness, got.gray));
				return;
			end
			want = expected_q.pop_front();
			if (got.hue_half_deg !== want.hue_half_deg || got.saturation !== want.saturation ||
			    got.brightness !== want.brightness || got.gray !== want.gray)
				report($sformatf("expected h=%0d s=%0d v=%0d y=%0d, got h=%0d s=%0d v=%0d y=%0d",
					want.hue_half_deg, want.saturation, want.brightness, want.gray,
					got.hue_half_deg, got.saturation, got.brightness, got.gray));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	bghg_pkg::pix_t pixel = '0;
	logic busy;
	logic done;
	bghg_pkg::res_t result;

	hsv_scoreboard sb;

	bgr_to_hsv_and_gray_pixel u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(pixel);
			if (done)
				sb.check_result(result);
		end
	end

	function automatic bghg_pkg::pix_t make_pixel(int b, int g, int r);
		bghg_pkg::pix_t p;
		p.blue = 8'(b);
		p.green = 8'(g);
		p.red = 8'(r);
		return p;
	endfunction

	function automatic logic [7:0] corner_value();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic bghg_pkg::pix_t random_pixel();
		bghg_pkg::pix_t p;
		logic [7:0] base;
		p = 24'($urandom);
		base = 8'($urandom);
		case ($urandom_range(0, 9))
			6: begin
				// two channels tie, third random
				case ($urandom_range(0, 2))
					0: p.green = p.red;
					1: p.blue = p.green;
					default: p.blue = p.red;
				endcase
			end
			7: p = {base, base, base};
			8: p = {corner_value(), corner_value(), corner_value()};
			9: begin
				// narrow span stresses the hue division
				p.blue = base ^ 8'($urandom_range(0, 3));
				p.green = base ^ 8'($urandom_range(0, 3));
				p.red = base ^ 8'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_pixel(input bghg_pkg::pix_t p);
		start <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		pixel <= 24'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		bghg_pkg::pix_t directed[$];
		bit idle_on;
		int waited;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		directed = '{
			make_pixel(0, 0, 0),       make_pixel(255, 255, 255), make_pixel(128, 128, 128),
			make_pixel(1, 1, 1),       make_pixel(0, 0, 255),     make_pixel(0, 255, 0),
			make_pixel(255, 0, 0),     make_pixel(0, 255, 255),   make_pixel(255, 255, 0),
			make_pixel(255, 0, 255),   make_pixel(200, 10, 255),  make_pixel(10, 200, 255),
			make_pixel(255, 10, 200),  make_pixel(10, 255, 200),  make_pixel(200, 255, 10),
			make_pixel(255, 200, 10),  make_pixel(254, 254, 255), make_pixel(0, 0, 1),
			make_pixel(1, 0, 0),       make_pixel(0, 1, 0),       make_pixel(100, 50, 100),
			make_pixel(170, 85, 0),    make_pixel(255, 254, 255)
		};
		foreach (directed[i]) begin
			send_pixel(directed[i]);
			if ($urandom_range(0, 2) == 0)
				hold_off($urandom_range(1, 5));
		end

		idle_on = 1'b1;
		for (int i = 0; i < NumRandom; i++) begin
			if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_pixel(random_pixel());
			if (i < NumRandom - QuietTail && idle_on && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 5));
		end
		start <= 1'b0;

		waited = 0;
		while (sb.pending() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		repeat (PipeDepth + 8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d requests never answered", sb.pending()));

		if (sb.mismatches == 0)
			$display("** bgr_to_hsv_and_gray_pixel: PASSED **");
		else
			$display("** bgr_to_hsv_and_gray_pixel: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** bgr_to_hsv_and_gray_pixel: FAILED **");
		$finish;
	end

endmodule
